>>> rtl/sprite_quad_vertex_transform_assert.svh
// assertion macros shared by the sprite quad transform modules
`ifndef SPRITE_QUAD_VERTEX_TRANSFORM_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_TRANSFORM_ASSERT_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define SQVT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while in reset
`define SQVT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sqvt_pkg.sv
// types, widths and cordic tables for the sprite quad transform
package sqvt_pkg;

    localparam int CORDIC_STEPS = 44;
    localparam int IDX_W        = $clog2(CORDIC_STEPS);
    localparam int XY_FRAC      = 46;
    localparam int XY_W         = 48;
    localparam int ANG_FRAC     = 31;
    localparam int ANG_R_W      = 14;
    localparam int Z_W          = 47;

    localparam int TRIG_W       = 16;
    localparam int TRIG_FRAC    = 14;
    localparam int TRIG_SHIFT   = XY_FRAC - TRIG_FRAC;

    localparam int DIM_W        = 31;
    localparam int SCALE_W      = 16;
    localparam int COORD_W      = 32;
    localparam int HALF_W       = DIM_W + 1 + SCALE_W;
    localparam int OFF_W        = COORD_W + 1;
    localparam int MUL_W        = HALF_W + TRIG_W;
    localparam int PROD_W       = 62;
    localparam int SUM_W        = PROD_W + 1;
    localparam int ROT_SHIFT    = 23;
    localparam int ROT_W        = SUM_W - ROT_SHIFT;
    localparam int FIN_W        = ROT_W + 1;

    localparam real PI_R       = 3.14159265358979323846;
    localparam real ATAN_SCALE = (2.0 ** (16 + ANG_FRAC)) / (2.0 * PI_R);

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;
    typedef enum logic [1:0] {CORNER_TL, CORNER_TR, CORNER_BL, CORNER_BR} corner_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    typedef struct packed {
        logic signed [HALF_W-1:0] a_prod;
        logic signed [HALF_W-1:0] b_prod;
        logic signed [OFF_W-1:0]  off_x;
        logic signed [OFF_W-1:0]  off_y;
        quad_t                    quad;
    } item_t;

    typedef logic signed [Z_W-1:0] atan_tab_t [CORDIC_STEPS];

    // atan(2^-i) in binary angle units scaled by 2^ANG_FRAC
    function automatic atan_tab_t build_atan_tab();
        atan_tab_t tab;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            tab[i] = Z_W'(longint'($atan(2.0 ** (-i)) * ATAN_SCALE));
        end
        return tab;
    endfunction

    // cordic length growth over all steps
    function automatic real cordic_growth();
        real g;
        g = 1.0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            g = g * $sqrt(1.0 + 2.0 ** (-2 * i));
        end
        return g;
    endfunction

    localparam real                    CORDIC_K  = 1.0 / cordic_growth();
    localparam atan_tab_t              ATAN_TAB  = build_atan_tab();
    localparam logic signed [XY_W-1:0] CORDIC_X0 =
        XY_W'(longint'(CORDIC_K * (2.0 ** XY_FRAC)));
    localparam logic signed [XY_W-1:0] TRIG_HALF =
        {{(XY_W - TRIG_SHIFT){1'b0}}, 1'b1, {(TRIG_SHIFT - 1){1'b0}}};

endpackage

>>> rtl/sqvt_cordic_cell.sv
// one cordic rotation cell with the sprite payload riding alongside
module sqvt_cordic_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic [sqvt_pkg::IDX_W-1:0] stage_idx,
    input  logic                   in_valid,
    input  sqvt_pkg::cordic_t      in_rot,
    input  sqvt_pkg::item_t        in_item,
    output logic                   out_valid,
    output sqvt_pkg::cordic_t      out_rot,
    output sqvt_pkg::item_t        out_item
);
    import sqvt_pkg::*;

    logic                   valid_reg;
    cordic_t                rot_reg;
    cordic_t                rot_next;
    item_t                  item_reg;
    logic                   rot_pos;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    logic signed [Z_W-1:0]  step_ang;

    assign rot_pos  = !in_rot.z[Z_W-1];
    assign x_sh     = $signed(in_rot.x) >>> stage_idx;
    assign y_sh     = $signed(in_rot.y) >>> stage_idx;
    assign step_ang = ATAN_TAB[stage_idx];

    always_comb begin
        if (rot_pos) begin
            rot_next.x = in_rot.x - y_sh;
            rot_next.y = in_rot.y + x_sh;
            rot_next.z = in_rot.z - step_ang;
        end else begin
            rot_next.x = in_rot.x + y_sh;
            rot_next.y = in_rot.y - x_sh;
            rot_next.z = in_rot.z + step_ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg  <= rot_next;
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;
    assign out_item  = item_reg;

endmodule

>>> rtl/sqvt_trig_round.sv
// rounds the cordic result to q2.14 and maps it to the angle quadrant
module sqvt_trig_round (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  sqvt_pkg::cordic_t              in_rot,
    input  sqvt_pkg::item_t                in_item,
    output logic                           out_valid,
    output logic signed [sqvt_pkg::TRIG_W-1:0] cos_q,
    output logic signed [sqvt_pkg::TRIG_W-1:0] sin_q,
    output sqvt_pkg::item_t                out_item
);
    import sqvt_pkg::*;

    logic                     valid_reg;
    logic signed [XY_W-1:0]   c_sum;
    logic signed [XY_W-1:0]   s_sum;
    logic signed [TRIG_W-1:0] c0;
    logic signed [TRIG_W-1:0] s0;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] sin_next;
    item_t                    item_reg;

    assign c_sum = in_rot.x + TRIG_HALF;
    assign s_sum = in_rot.y + TRIG_HALF;
    assign c0    = c_sum[TRIG_SHIFT +: TRIG_W];
    assign s0    = s_sum[TRIG_SHIFT +: TRIG_W];

    always_comb begin
        unique case (in_item.quad)
            QUAD_0: begin
                cos_next = c0;
                sin_next = s0;
            end
            QUAD_1: begin
                cos_next = -s0;
                sin_next = c0;
            end
            QUAD_2: begin
                cos_next = -c0;
                sin_next = -s0;
            end
            QUAD_3: begin
                cos_next = s0;
                sin_next = -c0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign cos_q     = cos_reg;
    assign sin_q     = sin_reg;
    assign out_item  = item_reg;

endmodule

>>> rtl/sqvt_corner_gen.sv
// forms the four rotated corners of a sprite and drives the result channel
`include "sprite_quad_vertex_transform_assert.svh"

module sqvt_corner_gen (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic signed [sqvt_pkg::TRIG_W-1:0] cos_q,
    input  logic signed [sqvt_pkg::TRIG_W-1:0] sin_q,
    input  sqvt_pkg::item_t                in_item,
    output logic                           in_take,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,  // vert_x, vert_y
    output logic [1:0]                     m_tuser,  // corner
    output logic                           m_tlast
);
    import sqvt_pkg::*;

    logic                      adv;

    logic signed [MUL_W-1:0]   prod_ac;
    logic signed [MUL_W-1:0]   prod_bs;
    logic signed [MUL_W-1:0]   prod_as;
    logic signed [MUL_W-1:0]   prod_bc;

    logic                      p_valid_reg, p_valid_next;
    corner_t                   p_cnt_reg, p_cnt_next;
    logic signed [PROD_W-1:0]  p_ac_reg, p_ac_next;
    logic signed [PROD_W-1:0]  p_bs_reg, p_bs_next;
    logic signed [PROD_W-1:0]  p_as_reg, p_as_next;
    logic signed [PROD_W-1:0]  p_bc_reg, p_bc_next;
    logic signed [OFF_W-1:0]   p_off_x_reg, p_off_x_next;
    logic signed [OFF_W-1:0]   p_off_y_reg, p_off_y_next;

    logic                      mid_valid_reg, mid_valid_next;
    corner_t                   mid_corner_reg, mid_corner_next;
    logic signed [SUM_W-1:0]   mid_rx_reg, mid_rx_next;
    logic signed [SUM_W-1:0]   mid_ry_reg, mid_ry_next;
    logic signed [OFF_W-1:0]   mid_off_x_reg, mid_off_x_next;
    logic signed [OFF_W-1:0]   mid_off_y_reg, mid_off_y_next;

    logic                      m_valid_reg, m_valid_next;
    corner_t                   m_corner_reg, m_corner_next;
    logic                      m_last_reg, m_last_next;
    logic [COORD_W-1:0]        m_x_reg, m_x_next;
    logic [COORD_W-1:0]        m_y_reg, m_y_next;

    logic                      x_pos;
    logic                      y_pos;
    logic signed [SUM_W-1:0]   ac_e, bs_e, as_e, bc_e;
    logic signed [SUM_W-1:0]   t_xc, t_ys, t_xs, t_yc;
    logic signed [ROT_W-1:0]   rot_x, rot_y;
    logic signed [FIN_W-1:0]   fin_x, fin_y;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [FIN_W-1:0] v);
        logic top_ones;
        logic top_zeros;
        top_ones  = &v[FIN_W-1:COORD_W-1];
        top_zeros = ~|v[FIN_W-1:COORD_W-1];
        if (top_ones || top_zeros) begin
            return v[COORD_W-1:0];
        end else if (v[FIN_W-1]) begin
            return {1'b1, {(COORD_W - 1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W - 1){1'b1}}};
        end
    endfunction

    assign prod_ac = MUL_W'($signed(in_item.a_prod)) * MUL_W'($signed(cos_q));
    assign prod_bs = MUL_W'($signed(in_item.b_prod)) * MUL_W'($signed(sin_q));
    assign prod_as = MUL_W'($signed(in_item.a_prod)) * MUL_W'($signed(sin_q));
    assign prod_bc = MUL_W'($signed(in_item.b_prod)) * MUL_W'($signed(cos_q));

    assign adv     = !m_valid_reg || m_tready;
    assign in_take = adv && (!p_valid_reg || (p_cnt_reg == CORNER_BR));

    // right corners have +w/2, top corners have +h/2
    assign x_pos = (p_cnt_reg == CORNER_TR) || (p_cnt_reg == CORNER_BR);
    assign y_pos = (p_cnt_reg == CORNER_TL) || (p_cnt_reg == CORNER_TR);

    assign ac_e = {p_ac_reg[PROD_W-1], p_ac_reg};
    assign bs_e = {p_bs_reg[PROD_W-1], p_bs_reg};
    assign as_e = {p_as_reg[PROD_W-1], p_as_reg};
    assign bc_e = {p_bc_reg[PROD_W-1], p_bc_reg};

    assign t_xc = x_pos ? ac_e : -ac_e;
    assign t_xs = x_pos ? as_e : -as_e;
    assign t_ys = y_pos ? bs_e : -bs_e;
    assign t_yc = y_pos ? bc_e : -bc_e;

    assign rot_x = mid_rx_reg[SUM_W-1:ROT_SHIFT];
    assign rot_y = mid_ry_reg[SUM_W-1:ROT_SHIFT];
    assign fin_x = $signed({{(FIN_W - ROT_W){rot_x[ROT_W-1]}}, rot_x})
                 + $signed({{(FIN_W - OFF_W){mid_off_x_reg[OFF_W-1]}}, mid_off_x_reg});
    assign fin_y = $signed({{(FIN_W - ROT_W){rot_y[ROT_W-1]}}, rot_y})
                 + $signed({{(FIN_W - OFF_W){mid_off_y_reg[OFF_W-1]}}, mid_off_y_reg});

    always_comb begin
        p_valid_next    = p_valid_reg;
        p_cnt_next      = p_cnt_reg;
        p_ac_next       = p_ac_reg;
        p_bs_next       = p_bs_reg;
        p_as_next       = p_as_reg;
        p_bc_next       = p_bc_reg;
        p_off_x_next    = p_off_x_reg;
        p_off_y_next    = p_off_y_reg;
        mid_valid_next  = mid_valid_reg;
        mid_corner_next = mid_corner_reg;
        mid_rx_next     = mid_rx_reg;
        mid_ry_next     = mid_ry_reg;
        mid_off_x_next  = mid_off_x_reg;
        mid_off_y_next  = mid_off_y_reg;
        m_valid_next    = m_valid_reg;
        m_corner_next   = m_corner_reg;
        m_last_next     = m_last_reg;
        m_x_next        = m_x_reg;
        m_y_next        = m_y_reg;
        if (adv) begin
            m_valid_next    = mid_valid_reg;
            m_corner_next   = mid_corner_reg;
            m_last_next     = (mid_corner_reg == CORNER_BR);
            m_x_next        = sat_coord(fin_x);
            m_y_next        = sat_coord(fin_y);
            mid_valid_next  = p_valid_reg;
            mid_corner_next = p_cnt_reg;
            mid_rx_next     = t_xc - t_ys;
            mid_ry_next     = t_xs + t_yc;
            mid_off_x_next  = p_off_x_reg;
            mid_off_y_next  = p_off_y_reg;
            if (in_take) begin
                p_valid_next = in_valid;
                p_cnt_next   = CORNER_TL;
                p_ac_next    = prod_ac[PROD_W-1:0];
                p_bs_next    = prod_bs[PROD_W-1:0];
                p_as_next    = prod_as[PROD_W-1:0];
                p_bc_next    = prod_bc[PROD_W-1:0];
                p_off_x_next = in_item.off_x;
                p_off_y_next = in_item.off_y;
            end else begin
                p_cnt_next   = corner_t'(p_cnt_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            p_cnt_reg     <= CORNER_TL;
            mid_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            p_valid_reg   <= p_valid_next;
            p_cnt_reg     <= p_cnt_next;
            mid_valid_reg <= mid_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_ac_reg       <= p_ac_next;
        p_bs_reg       <= p_bs_next;
        p_as_reg       <= p_as_next;
        p_bc_reg       <= p_bc_next;
        p_off_x_reg    <= p_off_x_next;
        p_off_y_reg    <= p_off_y_next;
        mid_corner_reg <= mid_corner_next;
        mid_rx_reg     <= mid_rx_next;
        mid_ry_reg     <= mid_ry_next;
        mid_off_x_reg  <= mid_off_x_next;
        mid_off_y_reg  <= mid_off_y_next;
        m_corner_reg   <= m_corner_next;
        m_last_reg     <= m_last_next;
        m_x_reg        <= m_x_next;
        m_y_reg        <= m_y_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_y_reg, m_x_reg};
    assign m_tuser  = m_corner_reg;
    assign m_tlast  = m_last_reg;

    `SQVT_ASSERT_IMP(a_products_held,
        p_valid_reg && (p_cnt_reg != CORNER_TL),
        $past(p_valid_reg) && $stable(p_ac_reg) && $stable(p_bs_reg) && $stable(p_bc_reg),
        "sprite products changed in the middle of a quad")
    `SQVT_ASSERT_NXT(a_stall_freezes_corner,
        m_valid_reg && !m_tready,
        $stable(p_valid_reg) && $stable(p_cnt_reg) && $stable(mid_valid_reg),
        "corner pipeline moved while the output stalled")

endmodule

>>> rtl/sprite_quad_vertex_transform.sv
// top level: sprite setup, cordic cell chain, trig rounding and corner output
//
// The slave channel takes one sprite per transaction: size, per-axis scale,
// binary angle, position and extra shift. For each sprite the master
// channel gives four transactions, the corners top-left, top-right,
// bottom-left and bottom-right, with the corner index in tuser and tlast on
// bottom-right.
// A sprite passes one setup stage, 44 cordic cells, rounding, products,
// corner sum and the output register before its first corner is valid;
// the other three follow one per cycle while the receiver does not stall.
// The corner generator puts one corner per cycle on the master channel
// and takes the next sprite as it forms the last corner of the one before.
// The cell chain holds up to 46 sprites in flight.
// Reset clears every valid flag; nothing else needs clearing, and the block
// accepts sprites in the first cycle after reset.
// When the receiver stalls, the output register holds its transaction and
// the corner generator freezes; once the sprite at the end of the chain
// cannot be handed over the whole chain holds and s_tready falls.
`include "sprite_quad_vertex_transform_assert.svh"

module sprite_quad_vertex_transform (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [239:0] s_tdata,   // width, height, scale_x, scale_y, angle,
                                    // pos_x, pos_y, shift_x, shift_y
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // vert_x, vert_y
    output logic [1:0]   m_tuser,   // corner
    output logic         m_tlast
);
    import sqvt_pkg::*;

    logic [DIM_W-1:0]          in_width;
    logic [DIM_W-1:0]          in_height;
    logic signed [SCALE_W-1:0] in_scale_x;
    logic signed [SCALE_W-1:0] in_scale_y;
    logic [15:0]               in_angle;
    logic signed [COORD_W-1:0] in_pos_x;
    logic signed [COORD_W-1:0] in_pos_y;
    logic signed [COORD_W-1:0] in_shift_x;
    logic signed [COORD_W-1:0] in_shift_y;

    logic                      chain_adv;
    logic                      prep_valid_reg;
    cordic_t                   prep_rot_reg, prep_rot_next;
    item_t                     prep_item_reg, prep_item_next;

    logic                      chain_valid [CORDIC_STEPS+1];
    cordic_t                   chain_rot   [CORDIC_STEPS+1];
    item_t                     chain_item  [CORDIC_STEPS+1];

    logic                      rnd_valid;
    logic signed [TRIG_W-1:0]  rnd_cos;
    logic signed [TRIG_W-1:0]  rnd_sin;
    item_t                     rnd_item;
    logic                      rnd_take;

    assign in_width   = s_tdata[30:0];
    assign in_height  = s_tdata[61:31];
    assign in_scale_x = s_tdata[77:62];
    assign in_scale_y = s_tdata[93:78];
    assign in_angle   = s_tdata[109:94];
    assign in_pos_x   = s_tdata[141:110];
    assign in_pos_y   = s_tdata[173:142];
    assign in_shift_x = s_tdata[205:174];
    assign in_shift_y = s_tdata[237:206];

    assign chain_adv = !rnd_valid || rnd_take;
    assign s_tready  = chain_adv;

    // width read as q30.1 is w/2, so the half size times scale needs no shift
    always_comb begin
        prep_item_next.a_prod = HALF_W'($signed({1'b0, in_width})) * HALF_W'(in_scale_x);
        prep_item_next.b_prod = HALF_W'($signed({1'b0, in_height})) * HALF_W'(in_scale_y);
        prep_item_next.off_x  = $signed({in_pos_x[COORD_W-1], in_pos_x})
                              + $signed({in_shift_x[COORD_W-1], in_shift_x});
        prep_item_next.off_y  = $signed({in_pos_y[COORD_W-1], in_pos_y})
                              + $signed({in_shift_y[COORD_W-1], in_shift_y});
        prep_item_next.quad   = quad_t'(in_angle[15:14]);
        prep_rot_next.x       = CORDIC_X0;
        prep_rot_next.y       = '0;
        prep_rot_next.z       = {{(Z_W - ANG_FRAC - ANG_R_W){1'b0}},
                                 in_angle[ANG_R_W-1:0], {ANG_FRAC{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (chain_adv) begin
            prep_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (chain_adv) begin
            prep_rot_reg  <= prep_rot_next;
            prep_item_reg <= prep_item_next;
        end
    end

    assign chain_valid[0] = prep_valid_reg;
    assign chain_rot[0]   = prep_rot_reg;
    assign chain_item[0]  = prep_item_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        sqvt_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (chain_adv),
            .stage_idx (IDX_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_rot    (chain_rot[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_rot   (chain_rot[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    sqvt_trig_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (chain_adv),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_rot    (chain_rot[CORDIC_STEPS]),
        .in_item   (chain_item[CORDIC_STEPS]),
        .out_valid (rnd_valid),
        .cos_q     (rnd_cos),
        .sin_q     (rnd_sin),
        .out_item  (rnd_item)
    );

    sqvt_corner_gen u_corner (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rnd_valid),
        .cos_q    (rnd_cos),
        .sin_q    (rnd_sin),
        .in_item  (rnd_item),
        .in_take  (rnd_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `SQVT_ASSERT_NXT(a_chain_end_held,
        rnd_valid && !rnd_take,
        rnd_valid && $stable(rnd_cos) && $stable(rnd_sin) && $stable(rnd_item),
        "sprite at the chain end changed before the corner generator took it")

endmodule
